@@ rtl/oaid_pkg.sv @@
package oaid_pkg;

    // Default number of entries in the element store
    localparam int CAPACITY_DEF = 1024;
    // Width of a position or a count at the default capacity
    localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 2;
    localparam int STAT_W       = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_READ   = 2'd3
    } req_kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

@@ rtl/oaid_req_if.sv @@
interface oaid_req_if
    import oaid_pkg::*;
#(
    parameter int CNT_W = CNT_W_DEF
);
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

@@ rtl/oaid_rsp_if.sv @@
interface oaid_rsp_if
    import oaid_pkg::*;
#(
    parameter int CNT_W = CNT_W_DEF
);
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         element_count;

    modport source (output valid, status, found, read_value, element_count, input ready);
    modport sink   (input valid, status, found, read_value, element_count, output ready);
endinterface

@@ rtl/oaid_mem.sv @@
module oaid_mem
    import oaid_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_W-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_W-1:0]            rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/oaid_ctrl.sv @@
module oaid_ctrl
    import oaid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    oaid_req_if.sink                    req,
    oaid_rsp_if.source                  rsp,
    output logic                        mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [DATA_W-1:0]           mem_wr_data,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    input  logic [DATA_W-1:0]           mem_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PUT,
        S_READ,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    req_kind_t           op_reg, op_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       last_reg, last_next;
    logic [AW-1:0]       dst_reg, dst_next;
    logic                issue_reg, issue_next;
    logic                pend_reg, pend_next;
    status_t             stat_reg, stat_next;
    logic                hit_reg, hit_next;
    logic [DATA_W-1:0]   rdv_reg, rdv_next;
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             rsp_stat_reg, rsp_stat_next;
    logic                rsp_found_reg, rsp_found_next;
    logic [DATA_W-1:0]   rsp_rdv_reg, rsp_rdv_next;
    logic [CW-1:0]       rsp_cnt_reg, rsp_cnt_next;

    logic                acc;
    logic [CW-1:0]       pos;
    logic [CW-1:0]       cnt_m1;
    logic                scan_down;

    assign acc       = req.valid && req.ready;
    assign pos       = req.position;
    assign cnt_m1    = count_reg - CW'(1);
    assign scan_down = (op_reg == REQ_INSERT);

    // Handshake and result outputs
    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_stat_reg;
    assign rsp.found         = rsp_found_reg;
    assign rsp.read_value    = rsp_rdv_reg;
    assign rsp.element_count = rsp_cnt_reg;

    // Memory read address: requested position when idle, scan pointer otherwise
    assign mem_rd_addr = (state_reg == S_IDLE) ? pos[AW-1:0] : addr_reg;

    // Memory write: move the element read last cycle, or place the inserted value
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = dst_reg;
        mem_wr_data = mem_rd_data;
        if (state_reg == S_SCAN && pend_reg && op_reg != REQ_SEARCH)
        begin
            mem_wr_en = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_reg[AW-1:0];
            mem_wr_data = val_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        dst_next       = dst_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        stat_next      = stat_reg;
        hit_next       = hit_reg;
        rdv_next       = rdv_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_stat_next  = rsp_stat_reg;
        rsp_found_next = rsp_found_reg;
        rsp_rdv_next   = rsp_rdv_reg;
        rsp_cnt_next   = rsp_cnt_reg;

        // Drop the result once the sink takes it
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    op_next    = req_kind_t'(req.req_type);
                    pos_next   = pos;
                    val_next   = req.value;
                    stat_next  = ST_OK;
                    hit_next   = 1'b0;
                    rdv_next   = '0;
                    issue_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    unique case (req_kind_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            if (pos > count_reg)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                addr_next  = cnt_m1[AW-1:0];
                                last_next  = pos[AW-1:0];
                                state_next = (pos == count_reg) ? S_PUT : S_SCAN;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (pos >= count_reg)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                addr_next  = pos[AW-1:0] + AW'(1);
                                last_next  = cnt_m1[AW-1:0];
                                state_next = (pos == cnt_m1) ? S_DONE : S_SCAN;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            addr_next  = '0;
                            last_next  = cnt_m1[AW-1:0];
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        REQ_READ:
                        begin
                            if (pos >= count_reg)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Advance the read pointer; its data arrives on the next cycle
                pend_next  = issue_reg;
                dst_next   = scan_down ? addr_reg + AW'(1) : addr_reg - AW'(1);
                issue_next = issue_reg && (addr_reg != last_reg);
                if (issue_reg)
                begin
                    addr_next = scan_down ? addr_reg - AW'(1) : addr_reg + AW'(1);
                end
                if (op_reg == REQ_SEARCH && pend_reg && mem_rd_data == val_reg)
                begin
                    hit_next = 1'b1;
                end
                if (!issue_reg && !pend_reg)
                begin
                    state_next = (op_reg == REQ_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_READ:
            begin
                rdv_next   = mem_rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_stat_next  = stat_reg;
                    rsp_found_next = hit_reg;
                    rsp_rdv_next   = rdv_reg;
                    rsp_cnt_next   = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= REQ_INSERT;
            count_reg     <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            addr_reg      <= '0;
            last_reg      <= '0;
            dst_reg       <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            stat_reg      <= ST_OK;
            hit_reg       <= 1'b0;
            rdv_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_stat_reg  <= ST_OK;
            rsp_found_reg <= 1'b0;
            rsp_rdv_reg   <= '0;
            rsp_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            addr_reg      <= addr_next;
            last_reg      <= last_next;
            dst_reg       <= dst_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            stat_reg      <= stat_next;
            hit_reg       <= hit_next;
            rdv_reg       <= rdv_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_stat_reg  <= rsp_stat_next;
            rsp_found_reg <= rsp_found_next;
            rsp_rdv_reg   <= rsp_rdv_next;
            rsp_cnt_reg   <= rsp_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_SCAN || state_reg == S_PUT))
        else $error("memory write outside shift or place step");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp_valid_reg && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("result overwrote a pending transaction");

    a_pend_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> $past(issue_reg))
        else $error("read data expected without a read issued");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result presented outside completion step");
`endif

endmodule

@@ rtl/ordered_array_insert_delete_search.sv @@
// Channel  Role    Payload                                      Transfer
// req      sink    req_type, position, value                    valid && ready
// rsp      source  status, found, read_value, element_count     valid && ready
//
// One request is processed at a time; req.ready is high only while the sequencer is idle.
// Insert shifts the elements from position onward up by one, and delete shifts those after
// position down by one; search compares every element against value, and read fetches one.
// A walk moves one element through the store's read port per cycle.
// The result sits in an output register, so a stalled rsp holds only the next completion.
// Reset clears the element count; store contents are undefined until written.
module ordered_array_insert_delete_search
    import oaid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    oaid_req_if.sink    req,
    oaid_rsp_if.source  rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    // Sequencer: checks, shifting walk, search compare, result register
    oaid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Element store
    oaid_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
